>>> rtl/assert_macros.svh
// assertion macros for the rtl file that checks its own behaviour
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define UBTR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define UBTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ubtr_pkg.sv
// types and codes for the buffered uart transmit and receive fifo block
// used by the controller, the datapath and the top level
package ubtr_pkg;

  typedef enum logic [1:0] {
    ACT_PUT     = 2'd0,
    ACT_GET     = 2'd1,
    ACT_TX_RDY  = 2'd2,
    ACT_RX_BYTE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TX_FULL  = 2'd1,
    ST_RX_EMPTY = 2'd2,
    ST_OVERRUN  = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_OUT  = 1'b1
  } fsm_state_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] read_byte;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       tx_irq_enable;
    logic       rx_irq_enable;
    logic [8:0] tx_level;
    logic [8:0] rx_level;
  } out_t;

  typedef struct packed {
    logic load;
  } ctrl_cmd_t;

endpackage

>>> rtl/ubtr_ctrl.sv
// handshake controller: sequences one transaction at a time into the datapath
// depends on ubtr_pkg
module ubtr_ctrl
  import ubtr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  fsm_state_e state_q, state_d;
  logic       load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    case (state_q)
      FSM_IDLE: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
      end
      FSM_OUT: begin
        in_stall_o  = out_stall_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
    load       = in_valid_i && !in_stall_o;
    cmd_o.load = load;
  end

  always_comb begin
    case (state_q)
      FSM_IDLE: state_d = load ? FSM_OUT : FSM_IDLE;
      FSM_OUT: begin
        if (out_stall_i) begin
          state_d = FSM_OUT;
        end else begin
          state_d = load ? FSM_OUT : FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

endmodule

>>> rtl/ubtr_datapath.sv
// fifo datapath: both ring buffers, pointers, counts, interrupt enables, result
// depends on ubtr_pkg
module ubtr_datapath
  import ubtr_pkg::*;
#(
  parameter int TX_DEPTH = 256,
  parameter int RX_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  in_t       in_data_i,
  output out_t      out_data_o
);

  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  logic [TX_AW-1:0] tx_rptr_q, tx_rptr_d, tx_wptr_q, tx_wptr_d;
  logic [RX_AW-1:0] rx_rptr_q, rx_rptr_d, rx_wptr_q, rx_wptr_d;
  logic [TX_CW-1:0] tx_cnt_q, tx_cnt_d;
  logic [RX_CW-1:0] rx_cnt_q, rx_cnt_d;
  logic             tx_en_q, tx_en_d, rx_en_q, rx_en_d;

  status_e    status_q, status_d;
  logic       get_hit_q, get_hit_d;
  logic       line_vld_q, line_vld_d;
  logic [7:0] tx_rd_q, rx_rd_q;

  logic tx_full, tx_empty, rx_full, rx_empty;
  logic tx_push, tx_pop, rx_push, rx_pop;

  logic [TX_CW+8:0] tx_lvl_ext;
  logic [RX_CW+8:0] rx_lvl_ext;

  assign tx_full  = (tx_cnt_q == TX_CW'(TX_DEPTH));
  assign tx_empty = (tx_cnt_q == '0);
  assign rx_full  = (rx_cnt_q == RX_CW'(RX_DEPTH));
  assign rx_empty = (rx_cnt_q == '0);

  always_comb begin
    tx_push    = 1'b0;
    tx_pop     = 1'b0;
    rx_push    = 1'b0;
    rx_pop     = 1'b0;
    tx_rptr_d  = tx_rptr_q;
    tx_wptr_d  = tx_wptr_q;
    rx_rptr_d  = rx_rptr_q;
    rx_wptr_d  = rx_wptr_q;
    tx_cnt_d   = tx_cnt_q;
    rx_cnt_d   = rx_cnt_q;
    tx_en_d    = tx_en_q;
    rx_en_d    = rx_en_q;
    status_d   = status_q;
    get_hit_d  = get_hit_q;
    line_vld_d = line_vld_q;
    if (cmd_i.load) begin
      status_d   = ST_OK;
      get_hit_d  = 1'b0;
      line_vld_d = 1'b0;
      case (in_data_i.action)
        ACT_PUT: begin
          if (tx_full) begin
            status_d = ST_TX_FULL;
          end else begin
            tx_push   = 1'b1;
            tx_wptr_d = (tx_wptr_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wptr_q + TX_AW'(1);
            tx_cnt_d  = tx_cnt_q + TX_CW'(1);
            tx_en_d   = 1'b1;
          end
        end
        ACT_GET: begin
          if (rx_empty) begin
            status_d = ST_RX_EMPTY;
          end else begin
            rx_pop    = 1'b1;
            get_hit_d = 1'b1;
            rx_rptr_d = (rx_rptr_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rptr_q + RX_AW'(1);
            rx_cnt_d  = rx_cnt_q - RX_CW'(1);
          end
          rx_en_d = 1'b1;
        end
        ACT_TX_RDY: begin
          if (!tx_empty) begin
            tx_pop     = 1'b1;
            line_vld_d = 1'b1;
            tx_rptr_d  = (tx_rptr_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rptr_q + TX_AW'(1);
            tx_cnt_d   = tx_cnt_q - TX_CW'(1);
          end
          if (tx_cnt_q <= TX_CW'(1)) begin
            tx_en_d = 1'b0;
          end
        end
        ACT_RX_BYTE: begin
          if (rx_full) begin
            status_d = ST_OVERRUN;
            rx_en_d  = 1'b0;
          end else begin
            rx_push   = 1'b1;
            rx_wptr_d = (rx_wptr_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wptr_q + RX_AW'(1);
            rx_cnt_d  = rx_cnt_q + RX_CW'(1);
            if (rx_cnt_q == RX_CW'(RX_DEPTH - 1)) begin
              rx_en_d = 1'b0;
            end
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_rptr_q <= '0;
      tx_wptr_q <= '0;
      rx_rptr_q <= '0;
      rx_wptr_q <= '0;
      tx_cnt_q  <= '0;
      rx_cnt_q  <= '0;
      tx_en_q   <= 1'b0;
      rx_en_q   <= 1'b1;
    end else begin
      tx_rptr_q <= tx_rptr_d;
      tx_wptr_q <= tx_wptr_d;
      rx_rptr_q <= rx_rptr_d;
      rx_wptr_q <= rx_wptr_d;
      tx_cnt_q  <= tx_cnt_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_en_q   <= tx_en_d;
      rx_en_q   <= rx_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    get_hit_q  <= get_hit_d;
    line_vld_q <= line_vld_d;
  end

  // transmit ring buffer
  always_ff @(posedge clk_i) begin
    if (tx_push) begin
      tx_mem[tx_wptr_q] <= in_data_i.data_byte;
    end
    if (tx_pop) begin
      tx_rd_q <= tx_mem[tx_rptr_q];
    end
  end

  // receive ring buffer
  always_ff @(posedge clk_i) begin
    if (rx_push) begin
      rx_mem[rx_wptr_q] <= in_data_i.data_byte;
    end
    if (rx_pop) begin
      rx_rd_q <= rx_mem[rx_rptr_q];
    end
  end

  assign tx_lvl_ext = {9'd0, tx_cnt_q};
  assign rx_lvl_ext = {9'd0, rx_cnt_q};

  always_comb begin
    out_data_o.status        = status_q;
    out_data_o.read_byte     = get_hit_q ? rx_rd_q : 8'd0;
    out_data_o.line_valid    = line_vld_q;
    out_data_o.line_byte     = line_vld_q ? tx_rd_q : 8'd0;
    out_data_o.tx_irq_enable = tx_en_q;
    out_data_o.rx_irq_enable = rx_en_q;
    out_data_o.tx_level      = tx_lvl_ext[8:0];
    out_data_o.rx_level      = rx_lvl_ext[8:0];
  end

endmodule

>>> rtl/uart_buffered_tx_rx_fifos.sv
// Buffered uart front end with a transmit fifo and a receive fifo. Each input
// transaction is one action (put, get, transmitter ready, byte received) and
// gives exactly one registered result in the cycle after it is accepted; a new transaction is
// taken in the same cycle that the previous result is taken, so the block runs
// at one transaction per cycle while the output is not stalled. The turnaround
// is set by the registered read port of each fifo memory. Memory contents need
// no clearing pass after reset; counts, pointers and interrupt enables reset.
// depends on ubtr_pkg, ubtr_ctrl, ubtr_datapath and assert_macros.svh
`include "assert_macros.svh"

module uart_buffered_tx_rx_fifos
  import ubtr_pkg::*;
#(
  parameter int TX_DEPTH = 256,
  parameter int RX_DEPTH = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  ctrl_cmd_t cmd;

  ubtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ubtr_datapath #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  `UBTR_ASSERT_NEXT(a_result_follows, in_valid_i && !in_stall_o, out_valid_o, "no result after transaction")
  `UBTR_ASSERT(a_no_accept_held, out_valid_o && out_stall_i, in_stall_o, "accepted while result held")
  `UBTR_ASSERT(a_tx_en_level, out_valid_o && !out_data_o.tx_irq_enable, out_data_o.tx_level == 9'd0, "tx enable low with bytes queued")
  `UBTR_ASSERT(a_line_ok, out_valid_o && out_data_o.line_valid, out_data_o.status == ST_OK, "line byte with error status")

endmodule

>>> dv/uart_fifo_checker.sv
// watches both channels of the buffered uart fifo block, predicts every result
// from its own copy of the fifo state and compares each accepted result
// depends on ubtr_pkg for the transaction structs and the action and status codes
module uart_fifo_checker
  import ubtr_pkg::*;
#(
  parameter int TX_DEPTH = 256,
  parameter int RX_DEPTH = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  int   tx_rd, tx_wr, tx_count;
  int   rx_rd, rx_wr, rx_count;
  logic tx_irq_en, rx_irq_en;
  out_t awaited_results [$];
  int   fails = 0;

  function automatic int next_slot(input int p, input int depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  function automatic out_t apply_action(input in_t item);
    out_t r;
    r = '0;
    r.status = ST_OK;
    case (item.action)
      ACT_PUT: begin
        if (tx_count >= TX_DEPTH) begin
          r.status = ST_TX_FULL;
        end else begin
          tx_mem[tx_wr] = item.data_byte;
          tx_wr = next_slot(tx_wr, TX_DEPTH);
          tx_count++;
          tx_irq_en = 1'b1;
        end
      end
      ACT_GET: begin
        if (rx_count == 0) begin
          r.status = ST_RX_EMPTY;
        end else begin
          r.read_byte = rx_mem[rx_rd];
          rx_rd = next_slot(rx_rd, RX_DEPTH);
          rx_count--;
        end
        rx_irq_en = 1'b1;
      end
      ACT_TX_RDY: begin
        if (tx_count > 0) begin
          r.line_valid = 1'b1;
          r.line_byte  = tx_mem[tx_rd];
          tx_rd = next_slot(tx_rd, TX_DEPTH);
          tx_count--;
        end
        if (tx_count == 0) tx_irq_en = 1'b0;
      end
      default: begin
        if (rx_count >= RX_DEPTH) begin
          r.status  = ST_OVERRUN;
          rx_irq_en = 1'b0;
        end else begin
          rx_mem[rx_wr] = item.data_byte;
          rx_wr = next_slot(rx_wr, RX_DEPTH);
          rx_count++;
          if (rx_count >= RX_DEPTH) rx_irq_en = 1'b0;
        end
      end
    endcase
    r.tx_irq_enable = tx_irq_en;
    r.rx_irq_enable = rx_irq_en;
    r.tx_level      = 9'(tx_count);
    r.rx_level      = 9'(rx_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s, got 0x%0h expected 0x%0h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin : watch
    out_t want;
    out_t got;
    if (!rst_ni) begin
      tx_rd = 0;
      tx_wr = 0;
      tx_count = 0;
      rx_rd = 0;
      rx_wr = 0;
      rx_count = 0;
      tx_irq_en = 1'b0;
      rx_irq_en = 1'b1;
    end else begin
      if (in_valid_i && !in_stall_i) awaited_results.push_back(apply_action(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no transaction waiting", 64'(got), 64'd0);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", 64'(got.read_byte), 64'(want.read_byte));
          if (got.line_valid !== want.line_valid)
            report_mismatch("line_valid", 64'(got.line_valid), 64'(want.line_valid));
          if (got.line_byte !== want.line_byte)
            report_mismatch("line_byte", 64'(got.line_byte), 64'(want.line_byte));
          if (got.tx_irq_enable !== want.tx_irq_enable)
            report_mismatch("tx_irq_enable", 64'(got.tx_irq_enable),
                            64'(want.tx_irq_enable));
          if (got.rx_irq_enable !== want.rx_irq_enable)
            report_mismatch("rx_irq_enable", 64'(got.rx_irq_enable),
                            64'(want.rx_irq_enable));
          if (got.tx_level !== want.tx_level)
            report_mismatch("tx_level", 64'(got.tx_level), 64'(want.tx_level));
          if (got.rx_level !== want.rx_level)
            report_mismatch("rx_level", 64'(got.rx_level), 64'(want.rx_level));
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= awaited_results.size();
  end

endmodule

>>> dv/uart_buffered_tx_rx_fifos_tb.sv
// stimulus and verdict for the buffered uart fifo block: directed actions, then
// random bursts that fill and drain both fifos under varying idle and stall rates
// depends on ubtr_pkg, uart_fifo_checker and the block itself
module uart_buffered_tx_rx_fifos_tb;
  import ubtr_pkg::*;

  localparam int TX_DEPTH   = 256;
  localparam int RX_DEPTH   = 256;
  localparam int RAND_ITEMS = 1900;
  localparam int PHASE_LEN  = 650;
  localparam int HOLD_LEN   = 400;

  typedef enum logic [1:0] {
    MIX_EVEN    = 2'd0,
    MIX_TX_FILL = 2'd1,
    MIX_RX_FILL = 2'd2,
    MIX_DRAIN   = 2'd3
  } mix_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  int   fail_count;
  int   pending;

  int   send_idle_pct = 18;
  int   recv_stall_pct = 88;
  int   items_sent = 0;
  bit   hold_req = 1'b0;
  bit   hold_given = 1'b0;
  int   hold_left = 0;

  uart_buffered_tx_rx_fifos #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  uart_fifo_checker #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(4 * 200000);
    $display("Test completed with failures");
    $finish;
  end

  // receiver side, with one long hold-off while the sender keeps offering items
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_given) begin
        hold_given = 1'b1;
        hold_left  = HOLD_LEN - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_item(input action_e act, input logic [7:0] b);
    in_t item;
    item.action    = act;
    item.data_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
    if (items_sent >= 2 * PHASE_LEN) begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req       = 1'b1;
    end else if (items_sent >= PHASE_LEN) begin
      send_idle_pct  = 88;
      recv_stall_pct = 18;
    end
  endtask

  function automatic action_e pick_action(input mix_e mix);
    int unsigned r;
    r = $urandom_range(99);
    case (mix)
      MIX_TX_FILL: return (r < 92) ? ACT_PUT : action_e'(2'($urandom_range(3)));
      MIX_RX_FILL: return (r < 92) ? ACT_RX_BYTE : action_e'(2'($urandom_range(3)));
      MIX_DRAIN: begin
        if (r < 45) return ACT_TX_RDY;
        if (r < 90) return ACT_GET;
        return action_e'(2'($urandom_range(3)));
      end
      default: return action_e'(2'($urandom_range(3)));
    endcase
  endfunction

  initial begin : stimulus
    mix_e mix;
    int   len;
    int   goal;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty fifos, both extremes of the byte, drain past empty
    send_item(ACT_GET, 8'h00);
    send_item(ACT_TX_RDY, 8'hff);
    send_item(ACT_PUT, 8'h00);
    send_item(ACT_PUT, 8'hff);
    send_item(ACT_PUT, 8'ha5);
    send_item(ACT_TX_RDY, 8'h00);
    send_item(ACT_TX_RDY, 8'h00);
    send_item(ACT_TX_RDY, 8'hff);
    send_item(ACT_TX_RDY, 8'h00);
    send_item(ACT_RX_BYTE, 8'h00);
    send_item(ACT_RX_BYTE, 8'hff);
    send_item(ACT_RX_BYTE, 8'h5a);
    send_item(ACT_GET, 8'hff);
    send_item(ACT_GET, 8'h00);
    send_item(ACT_GET, 8'h00);
    send_item(ACT_GET, 8'h00);
    send_item(ACT_PUT, 8'h3c);
    send_item(ACT_GET, 8'h00);
    send_item(ACT_TX_RDY, 8'h00);
    send_item(ACT_PUT, 8'hc3);
    send_item(ACT_RX_BYTE, 8'h81);

    // open with a fill of each fifo so that full, overrun and wrap are reached
    goal = items_sent + RAND_ITEMS;
    for (int i = 0; i < 290; i++) send_item(pick_action(MIX_TX_FILL), 8'($urandom()));
    for (int i = 0; i < 290; i++) send_item(pick_action(MIX_RX_FILL), 8'($urandom()));
    while (items_sent < goal) begin
      mix = mix_e'(2'($urandom_range(3)));
      len = $urandom_range(20, 300);
      for (int i = 0; i < len && items_sent < goal; i++)
        send_item(pick_action(mix), 8'($urandom()));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
